[design/slcd_pkg.sv]
// Shared types and constants of the sync, length and checksum deframer.
package slcd_pkg;

  // Default depth of the frame store in bytes.
  localparam int unsigned BufDepthDefault = 64;

  // Reset values of the sync byte registers.
  localparam logic [7:0] SyncFirstReset  = 8'hAA;
  localparam logic [7:0] SyncSecondReset = 8'h55;

  // Configuration register indexes, decoded from paddr[2].
  localparam logic RegSyncFirst  = 1'b0;
  localparam logic RegSyncSecond = 1'b1;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_CSUM_ERR = 2'd1,
    KIND_OVERSIZE = 2'd2
  } kind_e;

  // One result word as it sits in the result queue.
  typedef struct packed {
    kind_e      kind;
    logic [5:0] byte_index;
    logic [7:0] data_byte;
    logic       last;
  } result_t;

endpackage

[design/slcd_fifo.sv]
// Small register-based first-in first-out queue.
module slcd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] entry_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = entry_q[rd_ptr_q];

  // Pointer and fill count update with wrap at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[design/slcd_front.sv]
// Front end: sync hunt, length check, frame storing and checksum compare.
module slcd_front
  import slcd_pkg::*;
#(
  parameter int unsigned BufDepth = BufDepthDefault,
  parameter int unsigned AddrW    = $clog2(BufDepth),
  parameter int unsigned CntW     = $clog2(BufDepth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Received bytes
  input  logic             push_i,
  input  logic [7:0]       rx_byte_i,
  output logic             ready_o,
  // Sync byte values
  input  logic [7:0]       sync_first_i,
  input  logic [7:0]       sync_second_i,
  // Frame store write port
  output logic             mem_we_o,
  output logic [AddrW-1:0] mem_waddr_o,
  output logic [7:0]       mem_wdata_o,
  // Command queue
  output logic             cmd_push_o,
  output kind_e            cmd_kind_o,
  output logic [CntW-1:0]  cmd_count_o,
  input  logic             cmd_full_i,
  // Back end has read out the whole frame
  input  logic             frame_done_i
);

  // Compare width that holds the length, the count and BufDepth + 1.
  localparam int unsigned LenW = ((CntW > 8) ? CntW : 8) + 1;

  typedef enum logic [3:0] {
    ST_SYNC1 = 4'b0001,
    ST_SYNC2 = 4'b0010,
    ST_LEN   = 4'b0100,
    ST_BODY  = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      len_q, len_d;
  logic            lock_q, lock_d;
  logic            accept;
  logic            oversize;
  logic            store_body;

  // A good frame locks the input until the store has been read out.
  assign ready_o    = !cmd_full_i && !lock_q;
  assign accept     = push_i && ready_o;
  assign oversize   = LenW'(rx_byte_i) > LenW'(BufDepth + 1);
  assign store_body = (LenW'(count_q) + LenW'(1) < LenW'(len_q)) &&
                      (LenW'(count_q) < LenW'(BufDepth));

  assign mem_wdata_o = rx_byte_i;
  assign cmd_count_o = count_q;

  // Per-byte frame parsing.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    sum_d       = sum_q;
    len_d       = len_q;
    lock_d      = lock_q && !frame_done_i;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    cmd_push_o  = 1'b0;
    cmd_kind_o  = KIND_DATA;
    if (accept) begin
      unique case (state_q)
        ST_SYNC1: begin
          if (rx_byte_i == sync_first_i) begin
            mem_we_o = 1'b1;
            state_d  = ST_SYNC2;
          end
        end
        ST_SYNC2: begin
          if (rx_byte_i == sync_second_i) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = AddrW'(1);
            state_d     = ST_LEN;
          end else begin
            state_d = ST_SYNC1;
          end
        end
        ST_LEN: begin
          len_d = rx_byte_i;
          if (oversize) begin
            cmd_push_o = 1'b1;
            cmd_kind_o = KIND_OVERSIZE;
            state_d    = ST_SYNC1;
          end else begin
            mem_we_o    = 1'b1;
            mem_waddr_o = AddrW'(2);
            sum_d       = 8'(sync_first_i + sync_second_i + rx_byte_i);
            count_d     = CntW'(3);
            state_d     = ST_BODY;
          end
        end
        ST_BODY: begin
          if (store_body) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = count_q[AddrW-1:0];
            count_d     = count_q + CntW'(1);
            sum_d       = sum_q + rx_byte_i;
          end else begin
            // Checksum byte closes the frame.
            cmd_push_o = 1'b1;
            state_d    = ST_SYNC1;
            if (rx_byte_i != sum_q) begin
              cmd_kind_o = KIND_CSUM_ERR;
            end else begin
              lock_d = 1'b1;
            end
          end
        end
        default: state_d = ST_SYNC1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SYNC1;
      count_q <= '0;
      sum_q   <= '0;
      len_q   <= '0;
      lock_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      len_q   <= len_d;
      lock_q  <= lock_d;
    end
  end

endmodule

[design/slcd_back.sv]
// Back end: frame store and emitter that turns commands into result words.
module slcd_back
  import slcd_pkg::*;
#(
  parameter int unsigned BufDepth = BufDepthDefault,
  parameter int unsigned AddrW    = $clog2(BufDepth),
  parameter int unsigned CntW     = $clog2(BufDepth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Frame store write port
  input  logic             mem_we_i,
  input  logic [AddrW-1:0] mem_waddr_i,
  input  logic [7:0]       mem_wdata_i,
  // Command queue
  input  logic             cmd_empty_i,
  input  kind_e            cmd_kind_i,
  input  logic [CntW-1:0]  cmd_count_i,
  output logic             cmd_pop_o,
  // Result queue
  output logic             res_push_o,
  output result_t          res_word_o,
  input  logic             res_full_i,
  // Frame fully read out
  output logic             frame_done_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_PUSH = 3'b100
  } state_e;

  logic [7:0]       mem_q [BufDepth];
  logic [7:0]       rdata_q;
  state_e           state_q, state_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [CntW-1:0]  n_q, n_d;
  logic             is_last;

  // Frame store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we_i) begin
      mem_q[mem_waddr_i] <= mem_wdata_i;
    end
    if (state_q == ST_READ) begin
      rdata_q <= mem_q[idx_q];
    end
  end

  assign is_last = (CntW'(idx_q) + CntW'(1) == n_q);

  // Emitter sequencing: a status word per error command, a read and a push per byte.
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    n_d          = n_q;
    cmd_pop_o    = 1'b0;
    res_push_o   = 1'b0;
    frame_done_o = 1'b0;
    res_word_o   = '{kind: cmd_kind_i, byte_index: 6'd0, data_byte: 8'd0, last: 1'b1};
    unique case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          if (cmd_kind_i == KIND_DATA) begin
            cmd_pop_o = 1'b1;
            idx_d     = '0;
            n_d       = cmd_count_i;
            state_d   = ST_READ;
          end else if (!res_full_i) begin
            cmd_pop_o  = 1'b1;
            res_push_o = 1'b1;
          end
        end
      end
      ST_READ: state_d = ST_PUSH;
      ST_PUSH: begin
        res_word_o = '{kind: KIND_DATA, byte_index: 6'(idx_q), data_byte: rdata_q,
                       last: is_last};
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (is_last) begin
            frame_done_o = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            idx_d   = idx_q + AddrW'(1);
            state_d = ST_READ;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      n_q     <= n_d;
    end
  end

endmodule

[design/sync_length_checksum_deframer.sv]
// A frame's results go from its checksum byte through the command queue, the store
// read and the result queue. The front takes one byte per cycle while full is low;
// a good frame is emitted by a store read and a result push per byte, and input is
// held (full high) until its last byte enters the result queue.
// Reset: asynchronous, active low; clears queues and parsing, restores sync values.
// The frame store is not cleared; every emitted entry is written in the same frame.
module sync_length_checksum_deframer
  import slcd_pkg::*;
#(
  parameter int unsigned BufDepth = BufDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte input
  input  logic        push,
  input  logic [7:0]  rx_byte_i,
  output logic        full,
  // Result output
  input  logic        pop,
  output logic        empty,
  output logic [1:0]  kind_o,
  output logic [5:0]  byte_index_o,
  output logic [7:0]  data_byte_o,
  output logic        last_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AddrW = $clog2(BufDepth);
  localparam int unsigned CntW  = $clog2(BufDepth + 1);
  localparam int unsigned CmdW  = $bits(kind_e) + CntW;
  localparam int unsigned CmdDepth = 2;
  localparam int unsigned ResDepth = 4;

  logic [7:0]       sync_first_q, sync_second_q;
  logic             cfg_write;
  logic             front_ready;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic             cmd_push, cmd_pop, cmd_full, cmd_empty;
  kind_e            cmd_kind_w;
  logic [CntW-1:0]  cmd_count_w;
  logic [CmdW-1:0]  cmd_rdata;
  logic             frame_done;
  logic             res_push, res_full;
  result_t          res_wword, res_rword;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SyncFirstReset;
      sync_second_q <= SyncSecondReset;
    end else if (cfg_write) begin
      if (paddr[2] == RegSyncFirst) begin
        sync_first_q <= pwdata[7:0];
      end else begin
        sync_second_q <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[2] == RegSyncFirst) ? 32'(sync_first_q) : 32'(sync_second_q);

  assign full = !front_ready;

  slcd_front #(
    .BufDepth (BufDepth),
    .AddrW    (AddrW),
    .CntW     (CntW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .rx_byte_i     (rx_byte_i),
    .ready_o       (front_ready),
    .sync_first_i  (sync_first_q),
    .sync_second_i (sync_second_q),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .cmd_push_o    (cmd_push),
    .cmd_kind_o    (cmd_kind_w),
    .cmd_count_o   (cmd_count_w),
    .cmd_full_i    (cmd_full),
    .frame_done_i  (frame_done)
  );

  // Command queue between front and back.
  slcd_fifo #(
    .Width (CmdW),
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i ({cmd_kind_w, cmd_count_w}),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rdata),
    .empty_o (cmd_empty)
  );

  slcd_back #(
    .BufDepth (BufDepth),
    .AddrW    (AddrW),
    .CntW     (CntW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mem_we_i     (mem_we),
    .mem_waddr_i  (mem_waddr),
    .mem_wdata_i  (mem_wdata),
    .cmd_empty_i  (cmd_empty),
    .cmd_kind_i   (kind_e'(cmd_rdata[CmdW-1:CntW])),
    .cmd_count_i  (cmd_rdata[CntW-1:0]),
    .cmd_pop_o    (cmd_pop),
    .res_push_o   (res_push),
    .res_word_o   (res_wword),
    .res_full_i   (res_full),
    .frame_done_o (frame_done)
  );

  // Result queue in front of the output ports.
  slcd_fifo #(
    .Width ($bits(result_t)),
    .Depth (ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_wword),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rword),
    .empty_o (empty)
  );

  assign kind_o       = res_rword.kind;
  assign byte_index_o = res_rword.byte_index;
  assign data_byte_o  = res_rword.data_byte;
  assign last_o       = res_rword.last;

endmodule

[design/slcd_checker.sv]
// Port-level assertions for the deframer and their bind to the top level.
module slcd_checker
  import slcd_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       pop,
  input logic       empty,
  input logic [1:0] kind_o,
  input logic [5:0] byte_index_o,
  input logic [7:0] data_byte_o,
  input logic       last_o,
  input logic       pready
);

  // No result word is shown while reset is applied.
  assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result shown during reset");

  // Only the three defined kinds appear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (kind_o == KIND_DATA || kind_o == KIND_CSUM_ERR || kind_o == KIND_OVERSIZE))
    else $error("undefined result kind");

  // A status word is a single word with zero index and data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o != KIND_DATA) |-> (last_o && byte_index_o == 6'd0 &&
                                         data_byte_o == 8'd0))
    else $error("malformed status word");

  // Within a frame run the next word shown carries the next index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && kind_o == KIND_DATA && !last_o) |=>
      (empty || (kind_o == KIND_DATA &&
                 byte_index_o == 6'($past(byte_index_o) + 6'd1))))
    else $error("frame run index out of order");

  // The configuration port never inserts wait states.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind sync_length_checksum_deframer slcd_checker u_slcd_checker (.*);
